// ----- hw/rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the checker files.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, muted while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/mpt_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// MAC presence table package
// Types, codes and widths shared by the table modules.
// ---------------------------------------------------------------------------
package mpt_pkg;

   localparam int TABLE_DEPTH_DEF = 64;

   localparam int MAC_W    = 48;
   localparam int TTL_W    = 8;
   localparam int ONLINE_W = 32;
   localparam int IDX_W    = 6;
   localparam int FLEN_W   = 12;
   localparam int WENT_W   = 7;
   localparam int OP_W     = 2;

   localparam int REQ_DATA_W   = FLEN_W + MAC_W + IDX_W;
   localparam int REQ_TDATA_W  = 72;
   localparam int RSP_TDATA_W  = 112;

   localparam logic [FLEN_W-1:0] MIN_FRAME_LENGTH = 12'd24;
   localparam logic [TTL_W-1:0]  TTL_RELOAD_RESET = 8'd60;

   // opcodes
   localparam logic [OP_W-1:0] OP_FRAME = 2'd0;
   localparam logic [OP_W-1:0] OP_TICK  = 2'd1;
   localparam logic [OP_W-1:0] OP_READ  = 2'd2;

   typedef struct packed {
      logic [IDX_W-1:0]  read_index;
      logic [MAC_W-1:0]  source_mac;
      logic [FLEN_W-1:0] frame_length;
   } req_data_type;

   typedef struct packed {
      logic                offline;
      logic [ONLINE_W-1:0] online;
      logic [TTL_W-1:0]    ttl;
      logic [MAC_W-1:0]    mac;
   } entry_type;

   typedef struct packed {
      logic [WENT_W-1:0]   went_offline;
      logic [ONLINE_W-1:0] online_ticks;
      logic [TTL_W-1:0]    ttl_left;
      logic                entry_offline;
      logic                entry_valid;
      logic [MAC_W-1:0]    entry_mac;
      logic [IDX_W-1:0]    entry_index;
      logic                hit;
      logic                dropped;
   } result_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_TICK,
      ST_READ,
      ST_RESP
   } state_type;

endpackage

// ----- hw/rtl/mac_presence_table_with_aging_core.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// MAC presence table with aging
// Learns source addresses of received frames and ages them on time ticks.
// ---------------------------------------------------------------------------
// Each request word carries an opcode in req_tuser: frame seen, time tick or
// read entry. A frame shorter than the 24-byte header is dropped. A frame
// search walks the filled slots of the entry memory one per cycle and ends
// at the first hit, or on a miss after the last filled slot. A tick walks
// every filled slot with a read-modify-write pipeline and writes back the
// last slot before it ends. A read fetches the indexed slot. The single
// read port of the entry memory sets the pace of these walks. One request
// is in work at a time; a finished response sits in the output register so
// the next request is taken while it waits. Valid state comes from a fill
// count of written slots, so no clearing pass runs after reset. The TTL
// reload value is written through csr_wen / csr_wdata and resets to 60;
// the user must write it only while the block is idle, as the block
// itself does not enforce this.
// ---------------------------------------------------------------------------
module mac_presence_table_with_aging_core #(
   parameter int TABLE_DEPTH = mpt_pkg::TABLE_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // request words
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // frame_length[11:0], source_mac[59:12], read_index[65:60], zero fill
   input  logic [mpt_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // opcode[1:0]
   input  logic [mpt_pkg::OP_W-1:0]          req_tuser,
   // response words
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // dropped[0], hit[1], entry_index[7:2], entry_mac[55:8], entry_valid[56],
   // entry_offline[57], ttl_left[65:58], online_ticks[97:66],
   // went_offline[104:98], zero fill
   output logic [mpt_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // TTL reload register
   input  logic                              csr_wen,
   input  logic [mpt_pkg::TTL_W-1:0]         csr_wdata
);
   import mpt_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);

   logic [TTL_W-1:0]        ttl_reload_ff, ttl_reload_in;
   logic                    rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_TDATA_W-1:0]  rsp_tdata_ff, rsp_tdata_in;

   req_data_type            req_data;
   logic                    res_valid;
   logic                    res_ready;
   result_type              res;

   logic                    mem_wr_en;
   logic [AW-1:0]           mem_wr_addr;
   entry_type               mem_wr_data;
   logic                    mem_rd_en;
   logic [AW-1:0]           mem_rd_addr;
   entry_type               mem_rd_data;

   assign req_data = req_data_type'(req_tdata[REQ_DATA_W-1:0]);

   // hold the reload value until the next register write
   always_comb begin
      ttl_reload_in = ttl_reload_ff;
      if (csr_wen) begin
         ttl_reload_in = csr_wdata;
      end
   end

   // output register: load when empty or being drained, drop when taken
   assign res_ready = !rsp_tvalid_ff || rsp_tready;

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      if (res_valid && res_ready) begin
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = RSP_TDATA_W'(res);
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ttl_reload_ff <= TTL_RELOAD_RESET;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         ttl_reload_ff <= ttl_reload_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   mpt_engine #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_opcode  (req_tuser),
      .req_data    (req_data),
      .ttl_reload  (ttl_reload_ff),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res         (res),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   mpt_entry_mem #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_entry_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

// ----- hw/rtl/mpt_entry_mem.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// MAC presence table entry memory
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
module mpt_entry_mem #(
   parameter int  TABLE_DEPTH = mpt_pkg::TABLE_DEPTH_DEF,
   localparam int AW          = $clog2(TABLE_DEPTH)
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  mpt_pkg::entry_type  wr_data,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output mpt_pkg::entry_type  rd_data
);
   import mpt_pkg::*;

   entry_type mem_ff [TABLE_DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // hold the last read word while no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/mpt_engine.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// MAC presence table engine
// Sequencer that walks the entry memory for search, aging and read.
// ---------------------------------------------------------------------------
module mpt_engine #(
   parameter int  TABLE_DEPTH = mpt_pkg::TABLE_DEPTH_DEF,
   localparam int AW          = $clog2(TABLE_DEPTH)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [mpt_pkg::OP_W-1:0]    req_opcode,
   input  mpt_pkg::req_data_type       req_data,
   input  logic [mpt_pkg::TTL_W-1:0]   ttl_reload,
   output logic                        res_valid,
   input  logic                        res_ready,
   output mpt_pkg::result_type         res,
   output logic                        mem_wr_en,
   output logic [AW-1:0]               mem_wr_addr,
   output mpt_pkg::entry_type          mem_wr_data,
   output logic                        mem_rd_en,
   output logic [AW-1:0]               mem_rd_addr,
   input  mpt_pkg::entry_type          mem_rd_data
);
   import mpt_pkg::*;

   localparam int             FW         = $clog2(TABLE_DEPTH + 1);
   localparam logic [FW-1:0]  DepthCount = FW'(TABLE_DEPTH);
   localparam logic [AW-1:0]  LastSlot   = AW'(TABLE_DEPTH - 1);

   state_type          state_ff, state_in;
   logic [MAC_W-1:0]   mac_ff, mac_in;
   logic [IDX_W-1:0]   ridx_ff, ridx_in;
   logic [FW-1:0]      iss_ff, iss_in;
   logic [FW-1:0]      cnt_ff, cnt_in;
   logic [FW-1:0]      fill_ff, fill_in;
   logic               rvalid_ff, rvalid_in;
   logic [AW-1:0]      raddr_q_ff, raddr_q_in;
   logic [AW-1:0]      slot_ff, slot_in;
   result_type         res_ff, res_in;

   logic               hit_now;
   logic               walk_end;
   logic               ridx_in_range;
   logic               ridx_valid;
   logic               frame_short;
   entry_type          hit_entry;
   entry_type          aged_entry;
   entry_type          new_entry;
   logic               aged_drop;

   assign req_ready     = (state_ff == ST_IDLE);
   assign res_valid     = (state_ff == ST_RESP);
   assign res           = res_ff;
   assign hit_now       = rvalid_ff && (mem_rd_data.mac == mac_ff);
   assign walk_end      = (iss_ff == fill_ff);
   assign ridx_in_range = 32'(req_data.read_index) < 32'(TABLE_DEPTH);
   assign ridx_valid    = 32'(ridx_ff) < 32'(fill_ff);
   assign frame_short   = req_data.frame_length < MIN_FRAME_LENGTH;

   // entry rewrite for a sighting, an aging step and a fresh slot
   always_comb begin
      hit_entry     = mem_rd_data;
      hit_entry.ttl = ttl_reload;
      if (mem_rd_data.offline) begin
         hit_entry.offline = 1'b0;
         hit_entry.online  = '0;
      end

      aged_entry = mem_rd_data;
      aged_drop  = 1'b0;
      if (!mem_rd_data.offline && (mem_rd_data.online != '1)) begin
         aged_entry.online = mem_rd_data.online + 1'b1;
      end
      if (mem_rd_data.ttl <= 8'd1) begin
         aged_drop          = !mem_rd_data.offline;
         aged_entry.offline = 1'b1;
         aged_entry.ttl     = ttl_reload;
      end else begin
         aged_entry.ttl = mem_rd_data.ttl - 1'b1;
      end

      new_entry.offline = 1'b0;
      new_entry.online  = '0;
      new_entry.ttl     = ttl_reload;
      new_entry.mac     = mac_ff;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_opcode)
                  OP_FRAME: state_in = frame_short ? ST_RESP : ST_SEARCH;
                  OP_TICK:  state_in = ST_TICK;
                  OP_READ:  state_in = ridx_in_range ? ST_READ : ST_RESP;
                  default:  state_in = ST_RESP;
               endcase
            end
         end
         ST_SEARCH: begin
            if (hit_now || walk_end) begin
               state_in = ST_RESP;
            end
         end
         ST_TICK: begin
            if (walk_end && !rvalid_ff) begin
               state_in = ST_RESP;
            end
         end
         ST_READ: begin
            if (rvalid_ff) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      mac_in      = mac_ff;
      ridx_in     = ridx_ff;
      iss_in      = iss_ff;
      cnt_in      = cnt_ff;
      fill_in     = fill_ff;
      slot_in     = slot_ff;
      res_in      = res_ff;
      rvalid_in   = 1'b0;
      raddr_q_in  = raddr_q_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = raddr_q_ff;
      mem_wr_data = aged_entry;
      mem_rd_en   = 1'b0;
      mem_rd_addr = iss_ff[AW-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               mac_in  = req_data.source_mac;
               ridx_in = req_data.read_index;
               iss_in  = '0;
               cnt_in  = '0;
               res_in  = '0;
               if ((req_opcode == OP_FRAME) && frame_short) begin
                  res_in.dropped = 1'b1;
               end
               if (req_opcode == OP_READ) begin
                  res_in.entry_index = req_data.read_index;
               end
            end
         end
         ST_SEARCH: begin
            if (hit_now) begin
               mem_wr_en          = 1'b1;
               mem_wr_data        = hit_entry;
               res_in.hit         = 1'b1;
               res_in.entry_index = IDX_W'(raddr_q_ff);
            end else if (walk_end) begin
               // miss: take the slot under the wrapping pointer
               mem_wr_en          = 1'b1;
               mem_wr_addr        = slot_ff;
               mem_wr_data        = new_entry;
               res_in.entry_index = IDX_W'(slot_ff);
               slot_in            = (slot_ff == LastSlot) ? '0 : slot_ff + 1'b1;
               if (fill_ff != DepthCount) begin
                  fill_in = fill_ff + 1'b1;
               end
            end else begin
               mem_rd_en  = 1'b1;
               rvalid_in  = 1'b1;
               raddr_q_in = iss_ff[AW-1:0];
               iss_in     = iss_ff + 1'b1;
            end
         end
         ST_TICK: begin
            if (rvalid_ff) begin
               mem_wr_en = 1'b1;
               if (aged_drop) begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
            if (!walk_end) begin
               mem_rd_en  = 1'b1;
               rvalid_in  = 1'b1;
               raddr_q_in = iss_ff[AW-1:0];
               iss_in     = iss_ff + 1'b1;
            end else if (!rvalid_ff) begin
               res_in.went_offline = WENT_W'(cnt_ff);
            end
         end
         ST_READ: begin
            if (!rvalid_ff) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = AW'(ridx_ff);
               rvalid_in   = 1'b1;
            end else begin
               res_in.entry_mac     = mem_rd_data.mac;
               res_in.entry_valid   = ridx_valid;
               res_in.entry_offline = ridx_valid && mem_rd_data.offline;
               res_in.ttl_left      = mem_rd_data.ttl;
               res_in.online_ticks  = mem_rd_data.online;
            end
         end
         ST_RESP: begin
            rvalid_in = 1'b0;
         end
         default: begin
            rvalid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         rvalid_ff <= 1'b0;
         fill_ff   <= '0;
         slot_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         rvalid_ff <= rvalid_in;
         fill_ff   <= fill_in;
         slot_ff   <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      mac_ff     <= mac_in;
      ridx_ff    <= ridx_in;
      iss_ff     <= iss_in;
      cnt_ff     <= cnt_in;
      raddr_q_ff <= raddr_q_in;
      res_ff     <= res_in;
   end

endmodule

// ----- hw/rtl/mpt_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// MAC presence table checker
// Port-level checks, attached to the core by bind.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module mpt_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [mpt_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);
   import mpt_pkg::*;

   // a stalled response word holds
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "response word changed while stalled")

   // one request in work at a time
   `ASSERT_CLK(a_one_in_work, clock, reset, req_tvalid && req_tready |=> !req_tready, "request taken while busy")

   // a dropped frame reports no hit and slot zero
   `ASSERT_CLK(a_drop_clean, clock, reset, rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[7:1] == '0, "dropped frame with hit or index set")

   // only a valid slot can read as offline
   `ASSERT_CLK(a_offline_valid, clock, reset, rsp_tvalid && rsp_tdata[57] |-> rsp_tdata[56], "offline reported for an empty slot")

   // no response straight out of reset
   `ASSERT_CLK_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_tvalid, "response valid after reset")

endmodule

bind mac_presence_table_with_aging_core mpt_checker u_mpt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
